// File: design/isc_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 subnet calculator package
// Shared codes, constants, types and the bit count and low-ones helpers.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam logic [1:0] CMD_PREFIX   = 2'd0;
  localparam logic [1:0] CMD_NETMASK  = 2'd1;
  localparam logic [1:0] CMD_WILDCARD = 2'd2;
  localparam logic [1:0] CMD_CLASSFUL = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LENGTH   = 3'd1;
  localparam logic [2:0] ERR_NETMASK  = 3'd2;
  localparam logic [2:0] ERR_WILDCARD = 3'd3;
  localparam logic [2:0] ERR_CLASS    = 3'd4;
  localparam logic [2:0] ERR_RANGE    = 3'd5;

  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] CLASS_A_MASK = 32'hFF00_0000;
  localparam logic [31:0] CLASS_B_MASK = 32'hFFFF_0000;
  localparam logic [31:0] CLASS_C_MASK = 32'hFFFF_FF00;
  localparam logic [7:0]  CLASS_A_MAX  = 8'd127;
  localparam logic [7:0]  CLASS_B_MAX  = 8'd191;
  localparam logic [7:0]  CLASS_C_MAX  = 8'd223;
  localparam logic [5:0]  HOST_PREFIX_MAX = 6'd30;

  // Mask decision handed from the mask unit to the address unit.
  typedef struct packed {
    logic [2:0]  err;
    logic [31:0] mask;
    logic [5:0]  prefix;
  } mask_info_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [31:0] subnet_addr;
    logic [31:0] netmask_out;
    logic [31:0] wildcard_out;
    logic [31:0] bcast_addr;
    logic [31:0] host_min;
    logic [31:0] host_max;
    logic [5:0]  prefix_len;
    logic [32:0] total_addrs;
    logic        capacity_ok;
    logic        range_inside;
  } result_t;

  // Number of one bits in a word, summed as a five level adder tree.
  function automatic logic [5:0] ones_count(input logic [31:0] v);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) begin
      s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  // True when the word is a run of ones starting at bit 0 (zero included).
  function automatic logic low_ones(input logic [31:0] v);
    return (v & (v + 32'd1)) == 32'd0;
  endfunction

endpackage

// File: design/isc_mask_unit.sv
// ----------------------------------------------------------------------------
// IPv4 subnet calculator mask unit
// Picks the subnet mask from its source, checks it and counts its length.
// ----------------------------------------------------------------------------
module isc_mask_unit (
  input  logic [1:0]          cmd,
  input  logic [31:0]         ip_addr,
  input  logic [5:0]          prefix_in,
  input  logic [31:0]         mask_word,
  input  logic [31:0]         range_lo,
  input  logic [31:0]         range_hi,
  output isc_pkg::mask_info_t info
);

  logic [7:0]  top_octet;
  logic [2:0]  err;
  logic [31:0] mask;

  assign top_octet = ip_addr[31:24];

  always_comb begin
    err  = isc_pkg::ERR_NONE;
    mask = '0;
    unique case (cmd)
      isc_pkg::CMD_PREFIX: begin
        // A shift by 32 or more clears the word, so a length of 32 gives all ones.
        if (prefix_in > 6'd32) begin
          err = isc_pkg::ERR_LENGTH;
        end else begin
          mask = ~(isc_pkg::ALL_ONES >> prefix_in);
        end
      end
      isc_pkg::CMD_NETMASK: begin
        mask = mask_word;
        if (!isc_pkg::low_ones(~mask_word)) begin
          err = isc_pkg::ERR_NETMASK;
        end
      end
      isc_pkg::CMD_WILDCARD: begin
        mask = ~mask_word;
        if (!isc_pkg::low_ones(mask_word)) begin
          err = isc_pkg::ERR_WILDCARD;
        end
      end
      isc_pkg::CMD_CLASSFUL: begin
        if (top_octet <= isc_pkg::CLASS_A_MAX) begin
          mask = isc_pkg::CLASS_A_MASK;
        end else if (top_octet <= isc_pkg::CLASS_B_MAX) begin
          mask = isc_pkg::CLASS_B_MASK;
        end else if (top_octet <= isc_pkg::CLASS_C_MAX) begin
          mask = isc_pkg::CLASS_C_MASK;
        end else begin
          err = isc_pkg::ERR_CLASS;
        end
      end
      default: begin
        err = isc_pkg::ERR_CLASS;
      end
    endcase
    // A reversed range outranks every mask error.
    if (range_hi < range_lo) begin
      err = isc_pkg::ERR_RANGE;
    end
  end

  assign info.err    = err;
  assign info.mask   = mask;
  assign info.prefix = isc_pkg::ones_count(mask);

endmodule

// File: design/isc_addr_unit.sv
// ----------------------------------------------------------------------------
// IPv4 subnet calculator address unit
// Derives network, broadcast, host bounds and the capacity and range flags.
// ----------------------------------------------------------------------------
module isc_addr_unit (
  input  isc_pkg::mask_info_t info,
  input  logic [31:0]         ip_addr,
  input  logic [32:0]         cap_needed,
  input  logic [31:0]         range_lo,
  input  logic [31:0]         range_hi,
  output isc_pkg::result_t    result
);

  logic [31:0] net;
  logic [31:0] wild;
  logic [31:0] bcast;
  logic [32:0] total;
  logic        hosts;

  assign net   = ip_addr & info.mask;
  assign wild  = ~info.mask;
  assign bcast = net | wild;
  assign total = {1'b0, wild} + 33'd1;
  assign hosts = info.prefix <= isc_pkg::HOST_PREFIX_MAX;

  always_comb begin
    result = '0;
    result.error_code = info.err;
    if (info.err == isc_pkg::ERR_NONE) begin
      result.subnet_addr    = net;
      result.netmask_out    = info.mask;
      result.wildcard_out   = wild;
      result.bcast_addr     = bcast;
      result.host_min       = hosts ? net + 32'd1 : net;
      result.host_max       = hosts ? bcast - 32'd1 : bcast;
      result.prefix_len     = info.prefix;
      result.total_addrs    = total;
      result.capacity_ok    = (cap_needed == 33'd0) || (total >= cap_needed);
      result.range_inside   = ((range_lo == 32'd0) && (range_hi == 32'd0)) ||
                              ((range_lo >= net) && (range_hi <= bcast));
    end
  end

endmodule

// File: design/ipv4_subnet_calculator.sv
// ----------------------------------------------------------------------------
// IPv4 subnet calculator
// Single pass from address and mask source to subnet description.
// ----------------------------------------------------------------------------
// Usage: drive the input word on cmd, ip_addr, prefix_in, mask_word,
// cap_needed, range_lo and range_hi and raise start; the word is taken at
// the rising edge where start is high and busy is low. busy is high only
// while rst is high, so a new word may be given in every cycle.
// Each word is captured in the input register; the mask choice, mask check
// and address results are worked out in one pass of logic and land in the
// output register at the next edge. done is high for exactly one cycle,
// the cycle right after that edge, with the full result on the output
// ports. The receiver must take it then, as it cannot stall the block.
// Throughput is one word per cycle.
// Synchronous reset clears both valid bits, so words in flight are
// dropped and done stays low until new words arrive.
// ----------------------------------------------------------------------------
module ipv4_subnet_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] ip_addr,
  input  logic [5:0]  prefix_in,
  input  logic [31:0] mask_word,
  input  logic [32:0] cap_needed,
  input  logic [31:0] range_lo,
  input  logic [31:0] range_hi,
  output logic        done,
  output logic [2:0]  error_code,
  output logic [31:0] subnet_addr,
  output logic [31:0] netmask_out,
  output logic [31:0] wildcard_out,
  output logic [31:0] bcast_addr,
  output logic [31:0] host_min,
  output logic [31:0] host_max,
  output logic [5:0]  prefix_len,
  output logic [32:0] total_addrs,
  output logic        capacity_ok,
  output logic        range_inside
);

  logic accept;

  // Input register.
  logic        in_valid;
  logic [1:0]  in_cmd;
  logic [31:0] in_ip;
  logic [5:0]  in_prefix;
  logic [31:0] in_mask_word;
  logic [32:0] in_cap;
  logic [31:0] in_lo;
  logic [31:0] in_hi;

  isc_pkg::mask_info_t info;

  // Result register.
  isc_pkg::result_t result_next;
  isc_pkg::result_t result;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd       <= cmd;
      in_ip        <= ip_addr;
      in_prefix    <= prefix_in;
      in_mask_word <= mask_word;
      in_cap       <= cap_needed;
      in_lo        <= range_lo;
      in_hi        <= range_hi;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  isc_mask_unit u_mask (
    .cmd       (in_cmd),
    .ip_addr   (in_ip),
    .prefix_in (in_prefix),
    .mask_word (in_mask_word),
    .range_lo  (in_lo),
    .range_hi  (in_hi),
    .info      (info)
  );

  isc_addr_unit u_addr (
    .info       (info),
    .ip_addr    (in_ip),
    .cap_needed (in_cap),
    .range_lo   (in_lo),
    .range_hi   (in_hi),
    .result     (result_next)
  );

  assign error_code   = result.error_code;
  assign subnet_addr  = result.subnet_addr;
  assign netmask_out  = result.netmask_out;
  assign wildcard_out = result.wildcard_out;
  assign bcast_addr   = result.bcast_addr;
  assign host_min     = result.host_min;
  assign host_max     = result.host_max;
  assign prefix_len   = result.prefix_len;
  assign total_addrs  = result.total_addrs;
  assign capacity_ok  = result.capacity_ok;
  assign range_inside = result.range_inside;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted word did not produce a result two cycles later");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    (done && error_code != isc_pkg::ERR_NONE) |->
      (subnet_addr == 32'd0 && netmask_out == 32'd0 && total_addrs == 33'd0 &&
       !capacity_ok && !range_inside))
    else $error("result fields not cleared on error");

  a_wildcard: assert property (@(posedge clk) disable iff (rst)
    (done && error_code == isc_pkg::ERR_NONE) |->
      (wildcard_out == ~netmask_out &&
       total_addrs == {1'b0, wildcard_out} + 33'd1))
    else $error("wildcard or address count inconsistent with netmask");

  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (done && error_code == isc_pkg::ERR_NONE) |->
      (prefix_len <= 6'd32 &&
       bcast_addr == (subnet_addr | wildcard_out)))
    else $error("prefix length or broadcast out of line");
`endif

endmodule

// File: bench/ipv4_subnet_calculator_test.sv
// ----------------------------------------------------------------------------
// IPv4 subnet calculator testbench
// Sends address and mask words through the calculator with random gaps and
// compares every result word, field by field, against a local predictor.
// ----------------------------------------------------------------------------
module ipv4_subnet_calculator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GAP        = 17;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] ip;
    logic [5:0]  plen;
    logic [31:0] mword;
    logic [32:0] cap;
    logic [31:0] rlo;
    logic [31:0] rhi;
  } query_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = isc_pkg::CMD_PREFIX;
  logic [31:0] ip_addr = '0;
  logic [5:0]  prefix_in = '0;
  logic [31:0] mask_word = '0;
  logic [32:0] cap_needed = '0;
  logic [31:0] range_lo = '0;
  logic [31:0] range_hi = '0;
  logic        done;
  logic [2:0]  error_code;
  logic [31:0] subnet_addr;
  logic [31:0] netmask_out;
  logic [31:0] wildcard_out;
  logic [31:0] bcast_addr;
  logic [31:0] host_min;
  logic [31:0] host_max;
  logic [5:0]  prefix_len;
  logic [32:0] total_addrs;
  logic        capacity_ok;
  logic        range_inside;

  isc_pkg::result_t pending_subnets[$];
  int      mismatch_count = 0;
  int      stall_cycles = 0;
  int      burst_left = 0;

  ipv4_subnet_calculator i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .ip_addr      (ip_addr),
    .prefix_in    (prefix_in),
    .mask_word    (mask_word),
    .cap_needed   (cap_needed),
    .range_lo     (range_lo),
    .range_hi     (range_hi),
    .done         (done),
    .error_code   (error_code),
    .subnet_addr  (subnet_addr),
    .netmask_out  (netmask_out),
    .wildcard_out (wildcard_out),
    .bcast_addr   (bcast_addr),
    .host_min     (host_min),
    .host_max     (host_max),
    .prefix_len   (prefix_len),
    .total_addrs  (total_addrs),
    .capacity_ok  (capacity_ok),
    .range_inside (range_inside)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A run of ones from bit 0 (or zero) plus one is a single power of two.
  function automatic logic is_low_run(input logic [31:0] v);
    logic [32:0] sum;
    sum = {1'b0, v} + 33'd1;
    return $countones(sum) == 1;
  endfunction

  function automatic isc_pkg::result_t calc_subnet(input query_t q);
    isc_pkg::result_t r;
    logic [31:0] mask;
    logic [31:0] inv;
    logic [2:0]  err;
    r = '0;
    mask = '0;
    err = isc_pkg::ERR_NONE;
    if (q.rhi < q.rlo) begin
      err = isc_pkg::ERR_RANGE;
    end else begin
      case (q.cmd)
        isc_pkg::CMD_PREFIX: begin
          if (q.plen > 6'd32) err = isc_pkg::ERR_LENGTH;
          else mask = ~(isc_pkg::ALL_ONES >> q.plen);
        end
        isc_pkg::CMD_NETMASK: begin
          mask = q.mword;
          if (!is_low_run(~q.mword)) err = isc_pkg::ERR_NETMASK;
        end
        isc_pkg::CMD_WILDCARD: begin
          mask = ~q.mword;
          if (!is_low_run(q.mword)) err = isc_pkg::ERR_WILDCARD;
        end
        default: begin
          if (q.ip[31:24] <= isc_pkg::CLASS_A_MAX) mask = isc_pkg::CLASS_A_MASK;
          else if (q.ip[31:24] <= isc_pkg::CLASS_B_MAX) mask = isc_pkg::CLASS_B_MASK;
          else if (q.ip[31:24] <= isc_pkg::CLASS_C_MAX) mask = isc_pkg::CLASS_C_MASK;
          else err = isc_pkg::ERR_CLASS;
        end
      endcase
    end
    r.error_code = err;
    if (err == isc_pkg::ERR_NONE) begin
      inv = ~mask;
      r.netmask_out = mask;
      r.wildcard_out = inv;
      r.subnet_addr = q.ip & mask;
      r.bcast_addr = r.subnet_addr | inv;
      r.prefix_len = 6'($countones(mask));
      if (r.prefix_len <= isc_pkg::HOST_PREFIX_MAX) begin
        r.host_min = r.subnet_addr + 32'd1;
        r.host_max = r.bcast_addr - 32'd1;
      end else begin
        r.host_min = r.subnet_addr;
        r.host_max = r.bcast_addr;
      end
      r.total_addrs = {1'b0, inv} + 33'd1;
      r.capacity_ok = (q.cap == '0) || (r.total_addrs >= q.cap);
      r.range_inside = (q.rlo == '0 && q.rhi == '0) ||
                       (q.rlo >= r.subnet_addr && q.rhi <= r.bcast_addr);
    end
    return r;
  endfunction

  function automatic query_t make_query(input logic [1:0] c, input logic [31:0] ip,
                                        input logic [5:0] plen, input logic [31:0] mw,
                                        input logic [32:0] cap, input logic [31:0] lo,
                                        input logic [31:0] hi);
    query_t q;
    q.cmd = c;
    q.ip = ip;
    q.plen = plen;
    q.mword = mw;
    q.cap = cap;
    q.rlo = lo;
    q.rhi = hi;
    return q;
  endfunction

  // Mostly proper netmasks, some with one bit flipped, some fully random.
  function automatic logic [31:0] mask_like_word();
    logic [31:0] m;
    m = ~(isc_pkg::ALL_ONES >> $urandom_range(0, 32));
    case ($urandom_range(0, 6))
      0: m = $urandom;
      1: m = m ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    return m;
  endfunction

  // Zero, random values, and powers of two and their neighbors, which land on and around the subnet sizes.
  function automatic logic [32:0] pick_capacity();
    logic [32:0] pow;
    logic        top;
    pow = 33'd1 << $urandom_range(0, 32);
    top = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return {top, $urandom};
      2: return pow;
      default: return pow + 33'($urandom_range(0, 2)) - 33'd1;
    endcase
  endfunction

  function automatic void pick_range(input logic [31:0] ip, output logic [31:0] lo,
                                     output logic [31:0] hi);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] span;
    a = $urandom;
    b = $urandom;
    span = 32'd1 << $urandom_range(0, 24);
    case ($urandom_range(0, 9))
      0, 1: begin
        lo = '0;
        hi = '0;
      end
      2, 3, 4, 5: begin
        lo = ip - $urandom_range(0, span);
        hi = ip + $urandom_range(0, span);
      end
      6, 7, 8: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      default: begin
        lo = a;
        hi = b;
      end
    endcase
  endfunction

  function automatic query_t random_query(input logic [1:0] c);
    query_t q;
    q.cmd = c;
    q.ip = $urandom;
    q.plen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) :
                                           6'($urandom_range(0, 32));
    q.mword = (c == isc_pkg::CMD_WILDCARD) ? ~mask_like_word() : mask_like_word();
    q.cap = pick_capacity();
    pick_range(q.ip, q.rlo, q.rhi);
    return q;
  endfunction

  // Random gap before each word, with occasional back-to-back stretches.
  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Returns in the time step of the accepting edge, with start still high.
  task automatic send_word(input query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= q.cmd;
    ip_addr <= q.ip;
    prefix_in <= q.plen;
    mask_word <= q.mword;
    cap_needed <= q.cap;
    range_lo <= q.rlo;
    range_hi <= q.rhi;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_subnets.push_back(calc_subnet(q));
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_subnets.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input logic [32:0] want,
                               input logic [32:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) note_mismatch(name, want, got);
  endtask

  always @(posedge clk) begin : check_results
    isc_pkg::result_t want;
    if (done) begin
      if (pending_subnets.size() == 0) begin
        note_mismatch("result word with nothing pending", '0, {30'd0, error_code});
      end else begin
        want = pending_subnets.pop_front();
        check_field("error_code", 33'(want.error_code), 33'(error_code));
        check_field("subnet_addr", 33'(want.subnet_addr), 33'(subnet_addr));
        check_field("netmask_out", 33'(want.netmask_out), 33'(netmask_out));
        check_field("wildcard_out", 33'(want.wildcard_out), 33'(wildcard_out));
        check_field("bcast_addr", 33'(want.bcast_addr), 33'(bcast_addr));
        check_field("host_min", 33'(want.host_min), 33'(host_min));
        check_field("host_max", 33'(want.host_max), 33'(host_max));
        check_field("prefix_len", 33'(want.prefix_len), 33'(prefix_len));
        check_field("total_addrs", want.total_addrs, total_addrs);
        check_field("capacity_ok", 33'(want.capacity_ok), 33'(capacity_ok));
        check_field("range_inside", 33'(want.range_inside), 33'(range_inside));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ipv4_subnet_calculator_test NOT OK");
      $finish;
    end
  end

  task automatic test_corner_cases();
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h0000_0000, 6'd0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_PREFIX, isc_pkg::ALL_ONES, 6'd32, isc_pkg::ALL_ONES,
                         33'd1, isc_pkg::ALL_ONES, isc_pkg::ALL_ONES));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h0A01_0203, 6'd31, '0, 33'd3, '0, '0));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'hC0A8_0105, 6'd30, '0, 33'd4,
                         32'hC0A8_0104, 32'hC0A8_0107));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h0A00_0001, 6'd33, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h0A00_0001, 6'd63, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_PREFIX, isc_pkg::ALL_ONES, 6'd24, '0,
                         33'h1_FFFF_FFFF, '0, '0));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h1234_5678, 6'd0, '0, 33'h1_0000_0000,
                         '0, isc_pkg::ALL_ONES));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h8000_0000, 6'd1, '0, 33'h1_0000_0000,
                         '0, '0));
    send_word(make_query(isc_pkg::CMD_NETMASK, 32'hAC10_0001, '0, isc_pkg::ALL_ONES,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_NETMASK, 32'hAC10_0001, '0, 32'h0000_0000,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_NETMASK, 32'hAC10_0001, '0, 32'hFF00_FF00,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_NETMASK, 32'hAC10_0001, '0, 32'hFFFF_FFFE,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_WILDCARD, 32'h0A0B_0C0D, '0, 32'h0000_0000,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_WILDCARD, 32'h0A0B_0C0D, '0, isc_pkg::ALL_ONES,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_WILDCARD, 32'h0A0B_0C0D, '0, 32'h0000_00FE,
                         '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_WILDCARD, 32'hC0A8_0142, '0, 32'h0000_00FF, 33'd256,
                         32'hC0A8_0100, 32'hC0A8_01FF));
    send_word(make_query(isc_pkg::CMD_WILDCARD, 32'hC0A8_0142, '0, 32'h0000_00FF, 33'd257,
                         32'hC0A8_00FF, 32'hC0A8_01FF));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'h0000_0000, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'h7FFF_FFFF, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'h8000_0001, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'hBFFF_FFFF, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'hC000_0001, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'hDFFF_FFFF, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, 32'hE000_0001, '0, '0, '0, '0, '0));
    send_word(make_query(isc_pkg::CMD_CLASSFUL, isc_pkg::ALL_ONES, '0, '0, '0, '0, '0));
    // A reversed range wins over a good mask and over a length error.
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h0A00_0001, 6'd24, '0, '0, 32'd2, 32'd1));
    send_word(make_query(isc_pkg::CMD_PREFIX, 32'h0A00_0001, 6'd40, '0, '0,
                         isc_pkg::ALL_ONES, '0));
  endtask

  task automatic test_prefix_lengths();
    repeat (150) send_word(random_query(isc_pkg::CMD_PREFIX));
  endtask

  task automatic test_netmask_words();
    repeat (150) send_word(random_query(isc_pkg::CMD_NETMASK));
  endtask

  task automatic test_wildcard_words();
    repeat (150) send_word(random_query(isc_pkg::CMD_WILDCARD));
  endtask

  task automatic test_classful_defaults();
    repeat (100) send_word(random_query(isc_pkg::CMD_CLASSFUL));
  endtask

  task automatic test_mixed_with_drain();
    logic [1:0] c;
    for (int i = 0; i < 60; i++) begin
      if (i == 20 || i == 40) wait_for_drain();
      c = 2'($urandom_range(0, 3));
      send_word(random_query(c));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_prefix_lengths();
    test_netmask_words();
    test_wildcard_words();
    test_classful_defaults();
    test_mixed_with_drain();
    start <= 1'b0;
    while (pending_subnets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ipv4_subnet_calculator_test OK");
    end else begin
      $display("ipv4_subnet_calculator_test NOT OK");
    end
    $finish;
  end

endmodule
